[rtl/linear_interp_resampler_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Concurrent checks on the rising clock edge, switched off in reset. They
// expand to nothing when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

`ifndef SYNTHESIS
`define LIR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define LIR_ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`else
`define LIR_ASSERT_ALWAYS(label, expr, msg)
`define LIR_ASSERT_IMPLIES(label, cond, expr, msg)
`endif

`endif

[rtl/lir_pkg.sv]
// ---------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, limits, register indexes, sequencer states and the request and
// response types of the shared divider.
// ---------------------------------------------------------------------------
package lir_pkg;

  localparam int MAX_BLOCK = 4096;
  localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
  localparam int IDX_W     = $clog2(MAX_BLOCK);

  localparam int SAMPLE_W   = 16;
  localparam int BLEN_W     = 13;
  localparam int ROOM_W     = 15;
  localparam int IN_RATE_W  = 18;
  localparam int OUT_RATE_W = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 1;

  localparam int IN_RATE_MIN  = 8000;
  localparam int IN_RATE_MAX  = 192000;
  localparam int OUT_RATE_MIN = 8000;
  localparam int OUT_RATE_MAX = 48000;
  localparam int IN_RATE_RST  = 44100;
  localparam int OUT_RATE_RST = 48000;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = CFG_IDX_W'(1);

  localparam int MAX_OUT = 12;
  localparam int N_W     = $clog2(MAX_OUT + 1);

  localparam int FRAC_W          = 16;
  localparam int STEP_WHOLE_W    = $clog2(IN_RATE_MAX / OUT_RATE_MIN + 1);
  localparam int FRAC_LOW_SCALE  = 1000;
  localparam int FRAC_HIGH_SCALE = 999;
  localparam int THR_W           = $clog2(FRAC_LOW_SCALE * OUT_RATE_MAX + 1);

  localparam int DIV_W  = 32;
  localparam int DVR_W  = IN_RATE_W;
  localparam int DSTP_W = $clog2(DIV_W + 1);

  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int ACC_W   = PROD_W - FRAC_W;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CNT_MUL,
    ST_CNT_DIV,
    ST_CNT_WAIT,
    ST_STEP_DIV,
    ST_STEP_WAIT,
    ST_W_DIV,
    ST_W_WAIT,
    ST_FILT_MUL,
    ST_FILT_ADD,
    ST_CHECK,
    ST_SELECT,
    ST_F_DIV,
    ST_F_WAIT,
    ST_F_MUL,
    ST_F_ADD,
    ST_ADVANCE,
    ST_PRESENT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVR_W-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/lir_div.sv]
// ---------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold until the
// next start.
// ---------------------------------------------------------------------------
module lir_div (
  input  logic              clk,
  input  logic              rst,
  input  lir_pkg::div_req_t req,
  output lir_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic [lir_pkg::DSTP_W-1:0]  steps;
  logic [lir_pkg::DVR_W-1:0]   rem;
  logic [lir_pkg::DVR_W-1:0]   divisor;
  logic [lir_pkg::DIV_W-1:0]   qd;
  logic [lir_pkg::DVR_W:0]     trial;
  logic [lir_pkg::DVR_W:0]     diff;
  logic                        fits;

  always_comb begin
    trial = {rem, qd[lir_pkg::DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= lir_pkg::DSTP_W'(lir_pkg::DIV_W);
      end else if (busy) begin
        steps <= steps - lir_pkg::DSTP_W'(1);
        if (steps == lir_pkg::DSTP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      qd      <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[lir_pkg::DVR_W-1:0] : trial[lir_pkg::DVR_W-1:0];
      qd  <= {qd[lir_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = qd;
  assign rsp.remainder = rem;

endmodule

[rtl/lir_mul.sv]
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned by signed product with a registered result, used for the block
// length scaling, the lowpass weight and the interpolation fraction.
// ---------------------------------------------------------------------------
module lir_mul (
  input  logic                                clk,
  input  logic        [lir_pkg::MUL_A_W-1:0]  a,
  input  logic signed [lir_pkg::MUL_B_W-1:0]  b,
  output logic signed [lir_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, a}) * b;
  end

endmodule

[rtl/linear_interp_resampler.sv]
// ---------------------------------------------------------------------------
// Linear interpolation resampler
// Converts a block of mono samples from input_rate to output_rate, taking one
// sample per transaction and giving each output as soon as both neighbouring
// samples have arrived, at most twelve per input sample. A sequencer drives
// one shared divider and one multiplier. Each input sample passes the check
// and finish states, after the filter multiply and add with the lowpass on;
// each output passes select, advance and present, with a divide, multiply
// and add for the fraction after select when it falls between two samples
// and must be interpolated. The first sample of a block divides for the
// output count and rate step, and for the lowpass weight when it is needed.
// The input is not ready while a sample is being worked on; the last output
// may still wait in the output register while the next sample is taken.
// ---------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic        [lir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [lir_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]     sample,
  input  logic        [lir_pkg::BLEN_W-1:0]       block_length,
  input  logic        [lir_pkg::ROOM_W-1:0]       output_room,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0]     sample_out,
  output logic        [lir_pkg::ROOM_W-1:0]       out_index,
  output logic                                    run_last,
  output logic                                    block_last
);

  lir_pkg::state_t state, state_next;

  logic        [lir_pkg::IN_RATE_W-1:0]    input_rate;
  logic        [lir_pkg::OUT_RATE_W-1:0]   output_rate;

  logic        [lir_pkg::IDX_W-1:0]        in_count;
  logic        [lir_pkg::ROOM_W-1:0]       out_count;
  logic        [lir_pkg::ROOM_W-1:0]       out_target;
  logic signed [lir_pkg::SAMPLE_W-1:0]     prev_filtered;
  logic                                    filter_enable;
  logic        [lir_pkg::FRAC_W-1:0]       filter_weight;
  logic        [lir_pkg::LEN_W-1:0]        phase_whole;
  logic        [lir_pkg::OUT_RATE_W-1:0]   phase_remainder;
  logic        [lir_pkg::N_W-1:0]          emitted;

  logic        [lir_pkg::LEN_W-1:0]        block_len;
  logic        [lir_pkg::IN_RATE_W-1:0]    rate_in;
  logic        [lir_pkg::OUT_RATE_W-1:0]   rate_out;
  logic        [lir_pkg::ROOM_W-1:0]       room;
  logic        [lir_pkg::ROOM_W-1:0]       count;
  logic        [lir_pkg::STEP_WHOLE_W-1:0] step_whole;
  logic        [lir_pkg::OUT_RATE_W-1:0]   step_rem;
  logic        [lir_pkg::THR_W-1:0]        thr_high;
  logic signed [lir_pkg::SAMPLE_W-1:0]     x_in;
  logic signed [lir_pkg::SAMPLE_W-1:0]     y_cur;
  logic signed [lir_pkg::SAMPLE_W-1:0]     y_low;
  logic signed [lir_pkg::SAMPLE_W-1:0]     y_high;
  logic signed [lir_pkg::SAMPLE_W-1:0]     v_res;
  logic        [lir_pkg::ROOM_W-1:0]       res_index;
  logic                                    res_block_last;

  logic                                    in_fire;
  logic                                    out_load;
  logic                                    last_item;
  logic                                    loop_go;
  logic        [lir_pkg::LEN_W-1:0]        k_ext;
  logic        [lir_pkg::LEN_W:0]          pos_next;
  logic        [lir_pkg::LEN_W-1:0]        last_pos;
  logic        [lir_pkg::LEN_W-1:0]        upper_pos;
  logic signed [lir_pkg::SAMPLE_W-1:0]     y1;
  logic signed [lir_pkg::SAMPLE_W-1:0]     y2;
  logic                                    same_pos;
  logic        [lir_pkg::THR_W-1:0]        rem_scaled;
  logic                                    near_low;
  logic                                    near_high;
  logic        [lir_pkg::OUT_RATE_W:0]     rem_sum;
  logic                                    wrap;
  logic        [lir_pkg::OUT_RATE_W:0]     rem_wrapped;
  logic        [lir_pkg::LEN_W-1:0]        whole_next;
  logic        [lir_pkg::LEN_W-1:0]        blen_clamped;
  logic        [lir_pkg::IN_RATE_W-1:0]    rin_clamped;
  logic        [lir_pkg::OUT_RATE_W-1:0]   rout_clamped;
  logic        [lir_pkg::ROOM_W-1:0]       count_q;
  logic                                    count_small;
  logic        [lir_pkg::LEN_W-1:0]        weight_num;
  logic signed [lir_pkg::ACC_W-1:0]        prod_hi;
  logic signed [lir_pkg::SAMPLE_W-1:0]     mac_base;
  logic signed [lir_pkg::ACC_W-1:0]        mac_sum;

  logic        [lir_pkg::MUL_A_W-1:0]      mul_a;
  logic signed [lir_pkg::MUL_B_W-1:0]      mul_b;
  logic signed [lir_pkg::PROD_W-1:0]       prod;
  lir_pkg::div_req_t                       div_req;
  lir_pkg::div_rsp_t                       div_rsp;

  lir_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lir_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == lir_pkg::ST_PRESENT) && (!out_valid || out_ready);

  always_comb begin
    if (block_length == '0) begin
      blen_clamped = lir_pkg::LEN_W'(1);
    end else if (32'(block_length) > lir_pkg::MAX_BLOCK) begin
      blen_clamped = lir_pkg::LEN_W'(lir_pkg::MAX_BLOCK);
    end else begin
      blen_clamped = lir_pkg::LEN_W'(block_length);
    end
    if (input_rate < lir_pkg::IN_RATE_W'(lir_pkg::IN_RATE_MIN)) begin
      rin_clamped = lir_pkg::IN_RATE_W'(lir_pkg::IN_RATE_MIN);
    end else if (input_rate > lir_pkg::IN_RATE_W'(lir_pkg::IN_RATE_MAX)) begin
      rin_clamped = lir_pkg::IN_RATE_W'(lir_pkg::IN_RATE_MAX);
    end else begin
      rin_clamped = input_rate;
    end
    if (output_rate < lir_pkg::OUT_RATE_W'(lir_pkg::OUT_RATE_MIN)) begin
      rout_clamped = lir_pkg::OUT_RATE_W'(lir_pkg::OUT_RATE_MIN);
    end else if (output_rate > lir_pkg::OUT_RATE_W'(lir_pkg::OUT_RATE_MAX)) begin
      rout_clamped = lir_pkg::OUT_RATE_W'(lir_pkg::OUT_RATE_MAX);
    end else begin
      rout_clamped = output_rate;
    end
  end

  always_comb begin
    k_ext     = lir_pkg::LEN_W'(in_count);
    last_item = (k_ext + lir_pkg::LEN_W'(1)) >= block_len;
    loop_go   = (out_count < out_target) &&
                (emitted < lir_pkg::N_W'(lir_pkg::MAX_OUT)) &&
                (({1'b0, phase_whole} + (lir_pkg::LEN_W+1)'(1) <= {1'b0, k_ext}) ||
                 last_item);

    pos_next  = {1'b0, phase_whole} + (lir_pkg::LEN_W+1)'(1);
    last_pos  = block_len - lir_pkg::LEN_W'(1);
    upper_pos = (pos_next > {1'b0, last_pos}) ? last_pos : pos_next[lir_pkg::LEN_W-1:0];
    y1        = (phase_whole == k_ext) ? y_cur : prev_filtered;
    y2        = (upper_pos == k_ext) ? y_cur : prev_filtered;
    same_pos  = upper_pos == phase_whole;

    rem_scaled = lir_pkg::THR_W'(phase_remainder) * lir_pkg::THR_W'(lir_pkg::FRAC_LOW_SCALE);
    near_low   = rem_scaled < lir_pkg::THR_W'(rate_out);
    near_high  = rem_scaled > thr_high;

    rem_sum     = {1'b0, phase_remainder} + {1'b0, step_rem};
    wrap        = rem_sum >= {1'b0, rate_out};
    rem_wrapped = wrap ? rem_sum - {1'b0, rate_out} : rem_sum;
    whole_next  = phase_whole + lir_pkg::LEN_W'(step_whole) + lir_pkg::LEN_W'(wrap);

    count_q     = div_rsp.quotient[lir_pkg::ROOM_W-1:0];
    count_small = count_q < lir_pkg::ROOM_W'(block_len >> 1);
    weight_num  = block_len - lir_pkg::LEN_W'(count);

    prod_hi  = prod[lir_pkg::PROD_W-1:lir_pkg::FRAC_W];
    mac_base = (state == lir_pkg::ST_F_ADD) ? y_low : x_in;
    mac_sum  = lir_pkg::ACC_W'(mac_base) + prod_hi;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lir_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_count == '0) begin
            state_next = lir_pkg::ST_CNT_MUL;
          end else if (filter_enable) begin
            state_next = lir_pkg::ST_FILT_MUL;
          end else begin
            state_next = lir_pkg::ST_CHECK;
          end
        end
      end
      lir_pkg::ST_CNT_MUL:  state_next = lir_pkg::ST_CNT_DIV;
      lir_pkg::ST_CNT_DIV:  state_next = lir_pkg::ST_CNT_WAIT;
      lir_pkg::ST_CNT_WAIT: begin
        if (div_rsp.done) begin
          state_next = lir_pkg::ST_STEP_DIV;
        end
      end
      lir_pkg::ST_STEP_DIV: state_next = lir_pkg::ST_STEP_WAIT;
      lir_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_next = filter_enable ? lir_pkg::ST_W_DIV : lir_pkg::ST_CHECK;
        end
      end
      lir_pkg::ST_W_DIV:    state_next = lir_pkg::ST_W_WAIT;
      lir_pkg::ST_W_WAIT: begin
        if (div_rsp.done) begin
          state_next = lir_pkg::ST_CHECK;
        end
      end
      lir_pkg::ST_FILT_MUL: state_next = lir_pkg::ST_FILT_ADD;
      lir_pkg::ST_FILT_ADD: state_next = lir_pkg::ST_CHECK;
      lir_pkg::ST_CHECK: begin
        state_next = loop_go ? lir_pkg::ST_SELECT : lir_pkg::ST_FINISH;
      end
      lir_pkg::ST_SELECT: begin
        if (same_pos || near_low || near_high) begin
          state_next = lir_pkg::ST_ADVANCE;
        end else begin
          state_next = lir_pkg::ST_F_DIV;
        end
      end
      lir_pkg::ST_F_DIV:    state_next = lir_pkg::ST_F_WAIT;
      lir_pkg::ST_F_WAIT: begin
        if (div_rsp.done) begin
          state_next = lir_pkg::ST_F_MUL;
        end
      end
      lir_pkg::ST_F_MUL:    state_next = lir_pkg::ST_F_ADD;
      lir_pkg::ST_F_ADD:    state_next = lir_pkg::ST_ADVANCE;
      lir_pkg::ST_ADVANCE:  state_next = lir_pkg::ST_PRESENT;
      lir_pkg::ST_PRESENT: begin
        if (out_load) begin
          state_next = loop_go ? lir_pkg::ST_SELECT : lir_pkg::ST_FINISH;
        end
      end
      lir_pkg::ST_FINISH:   state_next = lir_pkg::ST_IDLE;
      default:              state_next = lir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = lir_pkg::DIV_W'(rate_in);
    div_req.divisor  = lir_pkg::DVR_W'(rate_out);
    mul_a            = '0;
    mul_b            = '0;
    unique case (state)
      lir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lir_pkg::ST_CNT_MUL: begin
        mul_a = rate_out;
        mul_b = signed'(lir_pkg::MUL_B_W'(block_len));
      end
      lir_pkg::ST_CNT_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[lir_pkg::DIV_W-1:0];
        div_req.divisor  = rate_in;
      end
      lir_pkg::ST_STEP_DIV: begin
        div_req.start = 1'b1;
      end
      lir_pkg::ST_W_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = lir_pkg::DIV_W'(weight_num) << lir_pkg::FRAC_W;
        div_req.divisor  = lir_pkg::DVR_W'(block_len);
      end
      lir_pkg::ST_FILT_MUL: begin
        mul_a = filter_weight;
        mul_b = lir_pkg::MUL_B_W'(prev_filtered) - lir_pkg::MUL_B_W'(x_in);
      end
      lir_pkg::ST_F_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = lir_pkg::DIV_W'(phase_remainder) << lir_pkg::FRAC_W;
      end
      lir_pkg::ST_F_MUL: begin
        mul_a = div_rsp.quotient[lir_pkg::MUL_A_W-1:0];
        mul_b = lir_pkg::MUL_B_W'(y_high) - lir_pkg::MUL_B_W'(y_low);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lir_pkg::ST_IDLE;
      input_rate      <= lir_pkg::IN_RATE_W'(lir_pkg::IN_RATE_RST);
      output_rate     <= lir_pkg::OUT_RATE_W'(lir_pkg::OUT_RATE_RST);
      in_count        <= '0;
      out_count       <= '0;
      out_target      <= '0;
      prev_filtered   <= '0;
      filter_enable   <= 1'b0;
      filter_weight   <= '0;
      phase_whole     <= '0;
      phase_remainder <= '0;
      emitted         <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == lir_pkg::REG_INPUT_RATE) begin
          input_rate <= cfg_data[lir_pkg::IN_RATE_W-1:0];
        end else if (cfg_index == lir_pkg::REG_OUTPUT_RATE) begin
          output_rate <= cfg_data[lir_pkg::OUT_RATE_W-1:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lir_pkg::ST_IDLE: begin
          if (in_fire) begin
            emitted <= '0;
            if (in_count == '0) begin
              out_count       <= '0;
              phase_whole     <= '0;
              phase_remainder <= '0;
            end
          end
        end
        lir_pkg::ST_CNT_WAIT: begin
          if (div_rsp.done) begin
            out_target    <= (count_q < room) ? count_q : room;
            filter_enable <= count_small;
            filter_weight <= '0;
          end
        end
        lir_pkg::ST_W_WAIT: begin
          if (div_rsp.done) begin
            if (|div_rsp.quotient[lir_pkg::DIV_W-1:lir_pkg::FRAC_W]) begin
              filter_weight <= '1;
            end else begin
              filter_weight <= div_rsp.quotient[lir_pkg::FRAC_W-1:0];
            end
          end
        end
        lir_pkg::ST_ADVANCE: begin
          out_count       <= out_count + lir_pkg::ROOM_W'(1);
          emitted         <= emitted + lir_pkg::N_W'(1);
          phase_remainder <= rem_wrapped[lir_pkg::OUT_RATE_W-1:0];
          phase_whole     <= whole_next;
        end
        lir_pkg::ST_FINISH: begin
          prev_filtered <= y_cur;
          in_count      <= last_item ? '0 : in_count + lir_pkg::IDX_W'(1);
        end
        default: begin
          emitted <= emitted;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lir_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_in  <= sample;
          y_cur <= sample;
          if (in_count == '0) begin
            block_len <= blen_clamped;
            rate_in   <= rin_clamped;
            rate_out  <= rout_clamped;
            room      <= output_room;
          end
        end
      end
      lir_pkg::ST_CNT_MUL: begin
        thr_high <= lir_pkg::THR_W'(rate_out) * lir_pkg::THR_W'(lir_pkg::FRAC_HIGH_SCALE);
      end
      lir_pkg::ST_CNT_WAIT: begin
        if (div_rsp.done) begin
          count <= count_q;
        end
      end
      lir_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          step_whole <= div_rsp.quotient[lir_pkg::STEP_WHOLE_W-1:0];
          step_rem   <= div_rsp.remainder[lir_pkg::OUT_RATE_W-1:0];
        end
      end
      lir_pkg::ST_FILT_ADD: begin
        y_cur <= mac_sum[lir_pkg::SAMPLE_W-1:0];
      end
      lir_pkg::ST_SELECT: begin
        y_low  <= y1;
        y_high <= y2;
        v_res  <= (same_pos || near_low) ? y1 : y2;
      end
      lir_pkg::ST_F_ADD: begin
        v_res <= mac_sum[lir_pkg::SAMPLE_W-1:0];
      end
      lir_pkg::ST_ADVANCE: begin
        res_index      <= out_count;
        res_block_last <= (out_count + lir_pkg::ROOM_W'(1)) == out_target;
      end
      lir_pkg::ST_PRESENT: begin
        if (out_load) begin
          sample_out <= v_res;
          out_index  <= res_index;
          run_last   <= !loop_go;
          block_last <= res_block_last;
        end
      end
      default: begin
        v_res <= v_res;
      end
    endcase
  end

  `LIR_ASSERT_ALWAYS(a_count_bound, out_count <= out_target, "output count passed its target")
  `LIR_ASSERT_ALWAYS(a_burst_bound, emitted <= lir_pkg::N_W'(lir_pkg::MAX_OUT), "too many outputs for one sample")
  `LIR_ASSERT_IMPLIES(a_last_ends_run, out_valid && block_last, run_last, "final output of a block does not end its run")
  `LIR_ASSERT_IMPLIES(a_phase_range, state == lir_pkg::ST_SELECT, phase_remainder < rate_out, "phase remainder not below the output rate")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the linear interpolation resampler
// Sends blocks of mono samples through the valid/ready input and checks every
// output transaction against a cycle-free predictor of the block: output
// count, lowpass, fraction thresholds and interpolation. Directed blocks cover
// the corner cases and a long hold-off of the output, then random blocks run
// under changing rates and random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  import lir_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 420;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [ROOM_W-1:0]          index;
    logic                       run_end;
    logic                       block_end;
  } resampled_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   sample;
  logic [BLEN_W-1:0]            block_length;
  logic [ROOM_W-1:0]            output_room;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [SAMPLE_W-1:0]   sample_out;
  logic [ROOM_W-1:0]            out_index;
  logic                         run_last;
  logic                         block_last;

  // Register copies and the per-block state of the predictor.
  int unsigned rate_in_reg = IN_RATE_RST;
  int unsigned rate_out_reg = OUT_RATE_RST;
  int unsigned samples_in = 0;
  int unsigned outs_done = 0;
  int unsigned outs_wanted = 0;
  int unsigned blk_len = 0;
  int unsigned step_whole = 0;
  int unsigned step_rem = 0;
  int unsigned rate_out_lat = 0;
  int unsigned phase_whole = 0;
  int unsigned phase_rem = 0;
  int unsigned lp_weight = 0;
  int          lp_prev = 0;
  bit          lp_on = 1'b0;

  resampled_t  pending_outs[$];
  int unsigned mismatch_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned rx_hold = 0;

  linear_interp_resampler dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void predict_resampled(logic signed [SAMPLE_W-1:0] s,
                                            logic [BLEN_W-1:0] bl,
                                            logic [ROOM_W-1:0] room);
    int x, y, y1, y2, v;
    int unsigned k, j2, ri, ro, cnt, n;
    longint acc, frac;
    longint unsigned r, wq;
    bit at_end;
    resampled_t o;
    x = s;
    if (samples_in == 0) begin
      blk_len = clamp_u(bl, 1, MAX_BLOCK);
      ri = clamp_u(rate_in_reg, IN_RATE_MIN, IN_RATE_MAX);
      ro = clamp_u(rate_out_reg, OUT_RATE_MIN, OUT_RATE_MAX);
      cnt = blk_len * ro / ri;
      rate_out_lat = ro;
      step_whole = ri / ro;
      step_rem = ri % ro;
      outs_wanted = (cnt < room) ? cnt : room;
      lp_on = cnt < blk_len / 2;
      wq = lp_on ? (64'(blk_len - cnt) << 16) / blk_len : 64'd0;
      lp_weight = (wq > 64'd65535) ? 65535 : 32'(wq);
      phase_whole = 0;
      phase_rem = 0;
      outs_done = 0;
      y = x;
    end else if (lp_on) begin
      acc = longint'(lp_weight) * lp_prev + longint'(65536 - lp_weight) * x;
      y = int'(acc >>> 16);
    end else begin
      y = x;
    end

    k = samples_in;
    at_end = (k + 1) >= blk_len;
    n = 0;
    while (outs_done < outs_wanted && n < MAX_OUT && (phase_whole + 1 <= k || at_end)) begin
      j2 = (phase_whole + 1 > blk_len - 1) ? blk_len - 1 : phase_whole + 1;
      y1 = (phase_whole == k) ? y : lp_prev;
      y2 = (j2 == k) ? y : lp_prev;
      r = phase_rem;
      if (j2 == phase_whole || r * FRAC_LOW_SCALE < rate_out_lat) begin
        v = y1;
      end else if (r * FRAC_LOW_SCALE > 64'(FRAC_HIGH_SCALE * rate_out_lat)) begin
        v = y2;
      end else begin
        frac = longint'((r << FRAC_W) / rate_out_lat);
        v = y1 + int'((frac * (y2 - y1)) >>> FRAC_W);
      end
      o.value = v[SAMPLE_W-1:0];
      o.index = outs_done[ROOM_W-1:0];
      o.run_end = 1'b0;
      o.block_end = (outs_done + 1 == outs_wanted);
      pending_outs.push_back(o);
      n++;
      outs_done++;
      phase_rem += step_rem;
      if (phase_rem >= rate_out_lat) begin
        phase_rem -= rate_out_lat;
        phase_whole++;
      end
      phase_whole += step_whole;
    end
    if (n != 0) begin
      o = pending_outs.pop_back();
      o.run_end = 1'b1;
      pending_outs.push_back(o);
    end
    lp_prev = y;
    samples_in = at_end ? 0 : k + 1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(string what, longint expv, longint got);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t: %s expected %0d, got %0d", $time, what, expv, got);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic [BLEN_W-1:0] bl,
                             logic [ROOM_W-1:0] room);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    block_length <= bl;
    output_room <= room;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_resampled(s, bl, room);
  endtask

  task automatic send_block(logic [BLEN_W-1:0] bl, logic [ROOM_W-1:0] room, int unsigned n);
    repeat (n) send_sample(rand_sample(), bl, room);
  endtask

  // Lets every expected transaction arrive, then gives the block time to
  // finish any sample that produces no output.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == REG_INPUT_RATE)
      rate_in_reg = value & 32'h3FFFF;
    else
      rate_out_reg = value & 32'hFFFF;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_rates(int unsigned in_hz, int unsigned out_hz);
    wait_idle();
    write_reg(REG_INPUT_RATE, in_hz);
    write_reg(REG_OUTPUT_RATE, out_hz);
  endtask

  task automatic test_reset_rates();
    send_sample(16'sh8000, 3, 15'h7FFF);
    send_sample(16'sh7FFF, 3, 15'h7FFF);
    send_sample(16'sh0000, 3, 15'h7FFF);
  endtask

  task automatic test_length_limits();
    send_sample(16'sh7FFF, 0, 15'h7FFF);
    send_sample(16'sh8000, 1, 1);
  endtask

  task automatic test_no_output();
    set_rates(192000, 8000);
    send_block(2, 15'h7FFF, 2);
    set_rates(IN_RATE_RST, OUT_RATE_RST);
    send_block(4, 0, 4);
  endtask

  task automatic test_rate_saturation();
    set_rates(0, 18'h3FFFF);
    send_block(2, 15'h7FFF, 2);
    set_rates(18'h3FFFF, 0);
    send_block(24, 15'h7FFF, 24);
  endtask

  task automatic test_upsample_bursts();
    set_rates(8000, 48000);
    send_block(3, 15'h7FFF, 3);
    send_block(4, 10, 4);
  endtask

  task automatic test_fraction_edges();
    set_rates(48001, 48000);
    send_block(3, 15'h7FFF, 3);
    set_rates(47999, 48000);
    send_block(3, 15'h7FFF, 3);
    set_rates(8008, 8000);
    send_block(3, 15'h7FFF, 3);
    set_rates(15992, 8000);
    send_block(4, 15'h7FFF, 4);
  endtask

  task automatic test_mid_block_change();
    set_rates(IN_RATE_RST, OUT_RATE_RST);
    send_block(6, 15'h7FFF, 3);
    set_rates(32000, 48000);
    send_block(13'h1FFF, 5, 3);
    send_block(4, 15'h7FFF, 4);
  endtask

  task automatic test_output_backpressure();
    set_rates(8000, 48000);
    rx_hold = 400;
    send_block(8, 15'h7FFF, 8);
  endtask

  task automatic test_longest_block();
    set_rates(192000, 8000);
    tx_gaps = 1'b0;
    send_block(13'h1FFF, 15'h7FFF, MAX_BLOCK);
    tx_gaps = 1'b1;
  endtask

  // Mostly whole blocks with random content; a phase may end inside a block,
  // so that the rates change while a block is still open.
  task automatic test_random_blocks();
    int unsigned sent, phase_end, ri, ro;
    logic [BLEN_W-1:0] bl;
    logic [ROOM_W-1:0] rm;
    sent = 0;
    bl = 1;
    rm = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: begin
          ri = $urandom_range(0, 262143);
          ro = $urandom_range(0, 65535);
        end
        1: begin
          ri = 8000;
          ro = 48000;
        end
        2: begin
          ri = 192000;
          ro = 8000;
        end
        default: begin
          ri = $urandom_range(IN_RATE_MIN, IN_RATE_MAX);
          ro = $urandom_range(OUT_RATE_MIN, OUT_RATE_MAX);
        end
      endcase
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_INPUT_RATE, ri);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_OUTPUT_RATE, ro);
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      phase_end = sent + $urandom_range(20, 50);
      while (sent < phase_end) begin
        if (samples_in == 0) begin
          case ($urandom_range(0, 9))
            0: bl = 0;
            1: bl = $urandom_range(30, 64);
            default: bl = $urandom_range(1, 16);
          endcase
          case ($urandom_range(0, 9))
            0: rm = 0;
            1, 2: rm = $urandom_range(1, 20);
            default: rm = $urandom_range(100, 32767);
          endcase
          send_sample(rand_sample(), bl, rm);
        end else if ($urandom_range(0, 3) == 0) begin
          send_sample(rand_sample(), $urandom, $urandom);
        end else begin
          send_sample(rand_sample(), bl, rm);
        end
        sent++;
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    block_length = '0;
    output_room = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_rates();
    test_length_limits();
    test_no_output();
    test_rate_saturation();
    test_upsample_bursts();
    test_fraction_edges();
    test_mid_block_change();
    test_output_backpressure();
    test_longest_block();
    test_random_blocks();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Output side: takes one transaction at a time and checks it against the
  // oldest pending prediction.
  initial begin
    int unsigned stall;
    resampled_t e;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 9) : 0;
      stall += rx_hold;
      rx_hold = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_outs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 50)
          $display("%0t: unexpected transaction, sample_out %0d out_index %0d",
                   $time, sample_out, out_index);
      end else begin
        e = pending_outs.pop_front();
        if (sample_out !== e.value)
          report("sample_out", $signed(e.value), sample_out);
        if (out_index !== e.index)
          report("out_index", e.index, out_index);
        if (run_last !== e.run_end)
          report("run_last", e.run_end, run_last);
        if (block_last !== e.block_end)
          report("block_last", e.block_end, block_last);
      end
      @(negedge clk);
    end
  end

  // Ends the run when no transaction has moved on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
